// ----- design/armored_base64_message_decoder_macros.svh -----
// Assertion helpers for the armored base64 decoder.
`ifndef ARMORED_BASE64_MESSAGE_DECODER_MACROS_SVH
`define ARMORED_BASE64_MESSAGE_DECODER_MACROS_SVH

`ifndef SYNTH
`define ABMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ABMD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ABMD_ASSERT_IMP(lbl, ante, cons)
`define ABMD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- design/abmd_pkg.sv -----
`default_nettype none
package abmd_pkg;

  localparam int MarkLen = 11;
  localparam int HdrLen  = 12;
  localparam int GrpLen  = 4;
  localparam int MaxRes  = 3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DATA = 2'd0;
  localparam kind_t KIND_DONE = 2'd1;
  localparam kind_t KIND_ERR  = 2'd2;

  localparam logic [7:0] CH_HYPHEN = 8'h2d;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_B      = 8'h42;

  // characters of the begin marker word, by position
  function automatic logic [7:0] mark_char(input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (pos)
      4'd0:    ch = 8'h42;
      4'd1:    ch = 8'h45;
      4'd2:    ch = 8'h47;
      4'd3:    ch = 8'h49;
      4'd4:    ch = 8'h4e;
      4'd5:    ch = 8'h20;
      4'd6:    ch = 8'h45;
      4'd7:    ch = 8'h43;
      4'd8:    ch = 8'h41;
      4'd9:    ch = 8'h53;
      4'd10:   ch = 8'h48;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // bit 6 set: not a base64 letter
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = 7'd64;
    if (c >= 8'h41 && c <= 8'h5a)      v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7a) v = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
    else if (c == 8'h2b)               v = 7'd62;
    else if (c == 8'h2f)               v = 7'd63;
    return v;
  endfunction

  // blanks other than line feed and carriage return, plus the '>' character
  function automatic logic is_soft_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0c || c == 8'h3e;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return is_soft_blank(c) || c == CH_LF || c == CH_CR;
  endfunction

endpackage
`default_nettype wire

// ----- design/armored_base64_message_decoder.sv -----
// Armored base64 message decoder.
// Input channel (in_valid/in_ready/in_byte): one text character per transaction.
// Output channel (out_valid/out_ready/out_kind/out_data_byte/out_last): one
// result per transaction; kind 0 is a decoded byte, 1 message complete,
// 2 format error. out_last marks the final result caused by one character.
// Each accepted character is parsed in the cycle it is accepted and its
// results (zero to three) land in a three-slot result register; the first
// result is visible the cycle after acceptance.
// Throughput: one character per cycle while each character yields at most one
// result and out_ready is high. The fourth character of a body group yields
// up to three bytes, which drain one per cycle through the result register
// while out_ready is high; a new character is taken once at most one result is
// left and it is being taken. When the receiver stalls, results hold and
// in_ready drops as soon as a result is pending that will not leave this cycle.
// Reset (rst_n low, synchronous) empties the result register and returns the
// parser to hunting for a leading hyphen. No clearing pass is needed.
`default_nettype none
module armored_base64_message_decoder (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [7:0]       in_byte,
  output logic             out_valid,
  input  wire              out_ready,
  output abmd_pkg::kind_t  out_kind,
  output logic [7:0]       out_data_byte,
  output logic             out_last
);
  import abmd_pkg::*;

  typedef enum logic [3:0] {
    P_HUNT       = 4'd0,
    P_LEAD       = 4'd1,
    P_MARK       = 4'd2,
    P_TO_HYPH    = 4'd3,
    P_HDR        = 4'd4,
    P_SEEK       = 4'd5,
    P_LEN        = 4'd6,
    P_BODY       = 4'd7,
    P_CLOSE_WAIT = 4'd8,
    P_CLOSE_RUN  = 4'd9,
    P_CLOSE_TEXT = 4'd10,
    P_CLOSE_CNT  = 4'd11
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  marker_pos_r, marker_pos_nxt;
  logic [1:0]  newline_run_r, newline_run_nxt;
  logic [1:0]  return_run_r, return_run_nxt;
  logic [3:0]  sextet_count_r, sextet_count_nxt;
  logic [23:0] bytes_left_r, bytes_left_nxt;
  logic [2:0]  closing_hyphens_r, closing_hyphens_nxt;
  logic [5:0]  sextet_store_r [HdrLen];

  kind_t       grp_kind_r [MaxRes];
  logic [7:0]  grp_data_r [MaxRes];
  logic [1:0]  grp_cnt_r;

  kind_t       gen_kind [MaxRes];
  logic [7:0]  gen_data [MaxRes];
  logic [1:0]  gen_cnt;

  logic        in_acc, out_acc;
  logic [7:0]  c;
  logic [6:0]  v, vb;
  logic        st_we;
  logic [3:0]  st_wa;
  logic [5:0]  st_wd;
  logic [5:0]  s [HdrLen];
  logic [1:0]  nl_inc, cr_inc;
  logic        hdr_bad;
  logic [23:0] len;
  logic [1:0]  take;
  logic [7:0]  b0, b1, b2;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign in_ready  = (grp_cnt_r == 2'd0) || (grp_cnt_r == 2'd1 && out_ready);
  assign out_valid = grp_cnt_r != 2'd0;
  assign out_kind      = grp_kind_r[0];
  assign out_data_byte = grp_data_r[0];
  assign out_last      = grp_cnt_r == 2'd1;

  assign c  = in_byte;
  assign v  = sextet_of(c);
  assign vb = (c == CH_EQUAL) ? 7'd0 : v;

  // sextet store as it reads after this character's write
  always_comb begin
    for (int i = 0; i < HdrLen; i++) begin
      s[i] = (st_we && st_wa == 4'(i)) ? st_wd : sextet_store_r[i];
    end
  end

  assign hdr_bad = s[0] != 6'h28 || s[1] != 6'h0b || s[2] != 6'h26 || s[3] != 6'h10 ||
                   s[4] != 6'h20 || s[5][5:4] != 2'b11 || s[9][3:0] != 4'ha ||
                   (s[10] & 6'h3c) != 6'h04;
  assign len = {s[5][3:0], s[6], s[7], s[8], s[9][5:4]};

  assign b0 = {s[0], s[1][5:4]};
  assign b1 = {s[1][3:0], s[2][5:2]};
  assign b2 = {s[2][1:0], s[3]};
  assign take = (bytes_left_r < 24'd3) ? bytes_left_r[1:0] : 2'd3;

  assign nl_inc = newline_run_r + 2'd1;
  assign cr_inc = return_run_r + 2'd1;

  always_comb begin
    phase_nxt           = phase_r;
    marker_pos_nxt      = marker_pos_r;
    newline_run_nxt     = newline_run_r;
    return_run_nxt      = return_run_r;
    sextet_count_nxt    = sextet_count_r;
    bytes_left_nxt      = bytes_left_r;
    closing_hyphens_nxt = closing_hyphens_r;
    st_we   = 1'b0;
    st_wa   = sextet_count_r;
    st_wd   = v[5:0];
    gen_cnt = 2'd0;
    for (int i = 0; i < MaxRes; i++) begin
      gen_kind[i] = KIND_DATA;
      gen_data[i] = 8'h00;
    end

    unique case (phase_r)
      P_HUNT: begin
        if (c == CH_HYPHEN) phase_nxt = P_LEAD;
      end
      P_LEAD: begin
        if (c == CH_B) begin
          phase_nxt      = P_MARK;
          marker_pos_nxt = 4'd1;
        end else if (c != CH_HYPHEN && !is_blank(c)) begin
          phase_nxt = P_HUNT;
        end
      end
      P_MARK: begin
        if (marker_pos_r < 4'(MarkLen) && c == mark_char(marker_pos_r)) begin
          if (marker_pos_r == 4'(MarkLen - 1)) begin
            phase_nxt      = P_TO_HYPH;
            marker_pos_nxt = 4'd0;
          end else begin
            marker_pos_nxt = marker_pos_r + 4'd1;
          end
        end else begin
          phase_nxt      = (c == CH_HYPHEN) ? P_LEAD : P_HUNT;
          marker_pos_nxt = 4'd0;
        end
      end
      P_TO_HYPH: begin
        if (c == CH_HYPHEN) begin
          phase_nxt       = P_HDR;
          newline_run_nxt = 2'd0;
          return_run_nxt  = 2'd0;
        end
      end
      P_HDR: begin
        if (c == CH_LF) begin
          newline_run_nxt = nl_inc;
        end else if (c == CH_CR) begin
          return_run_nxt = cr_inc;
        end else if (!is_soft_blank(c)) begin
          newline_run_nxt = 2'd0;
          return_run_nxt  = 2'd0;
        end
        // a second line break of the same type ends the header
        if ((c == CH_LF && nl_inc >= 2'd2) || (c == CH_CR && cr_inc >= 2'd2)) begin
          newline_run_nxt = 2'd0;
          return_run_nxt  = 2'd0;
          phase_nxt       = P_SEEK;
        end
      end
      P_SEEK: begin
        if (!v[6]) begin
          st_we            = 1'b1;
          st_wa            = 4'd0;
          sextet_count_nxt = 4'd1;
          phase_nxt        = P_LEN;
        end
      end
      P_LEN: begin
        if (!v[6] && sextet_count_r < 4'(HdrLen)) begin
          st_we            = 1'b1;
          sextet_count_nxt = sextet_count_r + 4'd1;
          if (sextet_count_r == 4'(HdrLen - 1)) begin
            sextet_count_nxt = 4'd0;
            if (hdr_bad) begin
              gen_cnt     = 2'd1;
              gen_kind[0] = KIND_ERR;
              phase_nxt   = P_HUNT;
              bytes_left_nxt = 24'd0;
            end else if (len != 24'd0) begin
              gen_cnt        = 2'd1;
              gen_data[0]    = {s[10][1:0], s[11]};
              bytes_left_nxt = len - 24'd1;
              phase_nxt      = (len != 24'd1) ? P_BODY : P_CLOSE_WAIT;
            end else begin
              bytes_left_nxt = 24'd0;
              phase_nxt      = P_CLOSE_WAIT;
            end
          end
        end
      end
      P_BODY: begin
        if (c == CH_HYPHEN) begin
          gen_cnt          = 2'd1;
          gen_kind[0]      = KIND_ERR;
          phase_nxt        = P_HUNT;
          sextet_count_nxt = 4'd0;
          bytes_left_nxt   = 24'd0;
        end else if (!vb[6] && sextet_count_r < 4'(GrpLen)) begin
          st_we            = 1'b1;
          st_wd            = vb[5:0];
          sextet_count_nxt = sextet_count_r + 4'd1;
          if (sextet_count_r == 4'(GrpLen - 1)) begin
            sextet_count_nxt = 4'd0;
            gen_cnt          = take;
            gen_data[0]      = b0;
            gen_data[1]      = b1;
            gen_data[2]      = b2;
            bytes_left_nxt   = bytes_left_r - {22'd0, take};
            if (bytes_left_r == {22'd0, take}) phase_nxt = P_CLOSE_WAIT;
          end
        end
      end
      P_CLOSE_WAIT: begin
        if (c == CH_HYPHEN) phase_nxt = P_CLOSE_RUN;
      end
      P_CLOSE_RUN: begin
        if (c != CH_HYPHEN && !is_blank(c)) phase_nxt = P_CLOSE_TEXT;
      end
      P_CLOSE_TEXT: begin
        if (c == CH_HYPHEN) begin
          phase_nxt           = P_CLOSE_CNT;
          closing_hyphens_nxt = 3'd1;
        end
      end
      P_CLOSE_CNT: begin
        if (c == CH_HYPHEN) begin
          closing_hyphens_nxt = closing_hyphens_r + 3'd1;
          if (closing_hyphens_r >= 3'd4) begin
            gen_cnt             = 2'd1;
            gen_kind[0]         = KIND_DONE;
            phase_nxt           = P_HUNT;
            closing_hyphens_nxt = 3'd0;
          end
        end else if (!is_blank(c)) begin
          gen_cnt             = 2'd1;
          gen_kind[0]         = KIND_DONE;
          phase_nxt           = P_HUNT;
          closing_hyphens_nxt = 3'd0;
        end
      end
      default: begin
        phase_nxt           = P_HUNT;
        marker_pos_nxt      = 4'd0;
        newline_run_nxt     = 2'd0;
        return_run_nxt      = 2'd0;
        sextet_count_nxt    = 4'd0;
        bytes_left_nxt      = 24'd0;
        closing_hyphens_nxt = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= P_HUNT;
      marker_pos_r      <= 4'd0;
      newline_run_r     <= 2'd0;
      return_run_r      <= 2'd0;
      sextet_count_r    <= 4'd0;
      bytes_left_r      <= 24'd0;
      closing_hyphens_r <= 3'd0;
      grp_cnt_r         <= 2'd0;
    end else begin
      if (in_acc) begin
        phase_r           <= phase_nxt;
        marker_pos_r      <= marker_pos_nxt;
        newline_run_r     <= newline_run_nxt;
        return_run_r      <= return_run_nxt;
        sextet_count_r    <= sextet_count_nxt;
        bytes_left_r      <= bytes_left_nxt;
        closing_hyphens_r <= closing_hyphens_nxt;
        if (st_we) sextet_store_r[st_wa] <= st_wd;
        grp_cnt_r <= gen_cnt;
        for (int i = 0; i < MaxRes; i++) begin
          grp_kind_r[i] <= gen_kind[i];
          grp_data_r[i] <= gen_data[i];
        end
      end else if (out_acc) begin
        // pop the head result
        grp_cnt_r <= grp_cnt_r - 2'd1;
        for (int i = 0; i < MaxRes - 1; i++) begin
          grp_kind_r[i] <= grp_kind_r[i + 1];
          grp_data_r[i] <= grp_data_r[i + 1];
        end
      end
    end
  end

`include "armored_base64_message_decoder_macros.svh"

  `ABMD_ASSERT_IMP(a_acc_room, in_valid && in_ready, grp_cnt_r <= 2'd1)
  `ABMD_ASSERT_IMP(a_body_left, phase_r == P_BODY, bytes_left_r != 24'd0)
  `ABMD_ASSERT_IMP(a_ctl_single, out_valid && out_kind != KIND_DATA, out_last)
  `ABMD_ASSERT_NXT(a_hunt_err, in_acc && gen_kind[0] == KIND_ERR, phase_r == P_HUNT)

endmodule
`default_nettype wire
